/* rtl/slr_shift_reduce_parser_assert.svh */
// ---------------------------------------------------------------------------
// SLR parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SLR_SHIFT_REDUCE_PARSER_ASSERT_SVH
`define SLR_SHIFT_REDUCE_PARSER_ASSERT_SVH

// condition holds at every edge out of reset
`define SLR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define SLR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/slr_pkg.sv */
// ---------------------------------------------------------------------------
// SLR parser package
// Grammar symbols, event codes, sequencer states and the parse tables.
// ---------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int MAX_CHAIN_DEF   = 64;

  localparam logic [5:0] NUM_TERM   = 6'd35;
  localparam logic [7:0] NUM_STATES = 8'd132;
  localparam logic [7:0] ACT_RED    = 8'd192;
  localparam logic [7:0] ACT_NONE   = 8'd255;
  localparam logic [5:0] NUM_RULES  = 6'd49;

  typedef enum logic [1:0] {
    EV_REDUCE = 2'd0,
    EV_SHIFT  = 2'd1,
    EV_ERROR  = 2'd2,
    EV_ACCEPT = 2'd3
  } slr_event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACT,
    ST_POP,
    ST_GOTO,
    ST_ACC,
    ST_ERR
  } slr_state_t;

  // terminals
  localparam logic [5:0] S_BOF = 6'd0, S_EOF = 6'd1, S_INT = 6'd2, S_ID = 6'd3;
  localparam logic [5:0] S_LPAREN = 6'd4, S_RPAREN = 6'd5, S_LBRACE = 6'd6;
  localparam logic [5:0] S_RETURN = 6'd7, S_SEMI = 6'd8, S_RBRACE = 6'd9;
  localparam logic [5:0] S_WAIN = 6'd10, S_COMMA = 6'd11, S_STAR = 6'd12;
  localparam logic [5:0] S_BECOMES = 6'd13, S_NUM = 6'd14, S_NULL = 6'd15;
  localparam logic [5:0] S_IF = 6'd16, S_ELSE = 6'd17, S_WHILE = 6'd18;
  localparam logic [5:0] S_PRINTLN = 6'd19, S_DELETE = 6'd20, S_LBRACK = 6'd21;
  localparam logic [5:0] S_RBRACK = 6'd22, S_EQ = 6'd23, S_NE = 6'd24;
  localparam logic [5:0] S_LT = 6'd25, S_LE = 6'd26, S_GE = 6'd27, S_GT = 6'd28;
  localparam logic [5:0] S_PLUS = 6'd29, S_MINUS = 6'd30, S_SLASH = 6'd31;
  localparam logic [5:0] S_PCT = 6'd32, S_AMP = 6'd33, S_NEW = 6'd34;
  // nonterminals
  localparam logic [5:0] N_START = 6'd35, N_PROCS = 6'd36, N_PROC = 6'd37;
  localparam logic [5:0] N_MAIN = 6'd38, N_PARAMS = 6'd39, N_PLIST = 6'd40;
  localparam logic [5:0] N_TYPE = 6'd41, N_DCLS = 6'd42, N_DCL = 6'd43;
  localparam logic [5:0] N_STMTS = 6'd44, N_STMT = 6'd45, N_TEST = 6'd46;
  localparam logic [5:0] N_EXPR = 6'd47, N_TERM = 6'd48, N_FACTOR = 6'd49;
  localparam logic [5:0] N_ARGS = 6'd50, N_LVAL = 6'd51;

  // lookahead sets
  localparam logic [34:0] MASK_C =
    (35'd1 << S_COMMA) | (35'd1 << S_EQ) | (35'd1 << S_GE) | (35'd1 << S_GT) |
    (35'd1 << S_LE) | (35'd1 << S_LT) | (35'd1 << S_MINUS) | (35'd1 << S_NE) |
    (35'd1 << S_PLUS) | (35'd1 << S_RBRACK) | (35'd1 << S_RPAREN) |
    (35'd1 << S_SEMI);
  localparam logic [34:0] MASK_B =
    MASK_C | (35'd1 << S_PCT) | (35'd1 << S_SLASH) | (35'd1 << S_STAR);
  localparam logic [34:0] MASK_A = MASK_B | (35'd1 << S_BECOMES);
  localparam logic [34:0] MASK_D =
    (35'd1 << S_DELETE) | (35'd1 << S_ID) | (35'd1 << S_IF) |
    (35'd1 << S_LPAREN) | (35'd1 << S_PRINTLN) | (35'd1 << S_RBRACE) |
    (35'd1 << S_RETURN) | (35'd1 << S_STAR) | (35'd1 << S_WHILE);
  localparam logic [34:0] MASK_E =
    (35'd1 << S_DELETE) | (35'd1 << S_ID) | (35'd1 << S_IF) |
    (35'd1 << S_INT) | (35'd1 << S_LPAREN) | (35'd1 << S_PRINTLN) |
    (35'd1 << S_RETURN) | (35'd1 << S_STAR) | (35'd1 << S_WHILE);
  localparam logic [34:0] MASK_F =
    (35'd1 << S_BECOMES) | (35'd1 << S_COMMA) | (35'd1 << S_RPAREN);
  localparam logic [34:0] L_EOF = 35'd1 << S_EOF;
  localparam logic [34:0] L_RP  = 35'd1 << S_RPAREN;
  localparam logic [34:0] L_ID  = 35'd1 << S_ID;
  localparam logic [34:0] L_INT = 35'd1 << S_INT;

  // rule length [8:5], head offset from N_START [4:0]
  function automatic logic [8:0] rule_info(input logic [5:0] r);
    logic [8:0] v;
    v = '0;
    unique case (r)
      6'd0: v = {4'd3, 5'd0};
      6'd1: v = {4'd2, 5'd1};
      6'd2: v = {4'd1, 5'd1};
      6'd3: v = {4'd12, 5'd2};
      6'd4: v = {4'd14, 5'd3};
      6'd5: v = {4'd0, 5'd4};
      6'd6: v = {4'd1, 5'd4};
      6'd7: v = {4'd1, 5'd5};
      6'd8: v = {4'd3, 5'd5};
      6'd9: v = {4'd1, 5'd6};
      6'd10: v = {4'd2, 5'd6};
      6'd11: v = {4'd0, 5'd7};
      6'd12, 6'd13: v = {4'd5, 5'd7};
      6'd14: v = {4'd2, 5'd8};
      6'd15: v = {4'd0, 5'd9};
      6'd16: v = {4'd2, 5'd9};
      6'd17: v = {4'd4, 5'd10};
      6'd18: v = {4'd11, 5'd10};
      6'd19: v = {4'd7, 5'd10};
      6'd20, 6'd21: v = {4'd5, 5'd10};
      6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27: v = {4'd3, 5'd11};
      6'd28: v = {4'd1, 5'd12};
      6'd29, 6'd30: v = {4'd3, 5'd12};
      6'd31: v = {4'd1, 5'd13};
      6'd32, 6'd33, 6'd34: v = {4'd3, 5'd13};
      6'd35, 6'd36, 6'd37: v = {4'd1, 5'd14};
      6'd38: v = {4'd3, 5'd14};
      6'd39, 6'd40: v = {4'd2, 5'd14};
      6'd41: v = {4'd5, 5'd14};
      6'd42: v = {4'd3, 5'd14};
      6'd43: v = {4'd4, 5'd14};
      6'd44: v = {4'd1, 5'd15};
      6'd45: v = {4'd3, 5'd15};
      6'd46: v = {4'd1, 5'd16};
      6'd47: v = {4'd2, 5'd16};
      6'd48: v = {4'd3, 5'd16};
      default: v = '0;
    endcase
    return v;
  endfunction

  // reduction of a state: {valid, rule, lookahead set}
  function automatic logic [41:0] red_info(input logic [7:0] st);
    logic [41:0] v;
    v = '0;
    unique case (st)
      8'd10: v = {1'b1, 6'd36, MASK_A};
      8'd112: v = {1'b1, 6'd38, MASK_A};
      8'd13: v = {1'b1, 6'd35, MASK_A};
      8'd130: v = {1'b1, 6'd48, MASK_A};
      8'd19: v = {1'b1, 6'd46, MASK_A};
      8'd24: v = {1'b1, 6'd43, MASK_A};
      8'd26: v = {1'b1, 6'd40, MASK_A};
      8'd33: v = {1'b1, 6'd37, MASK_A};
      8'd44: v = {1'b1, 6'd42, MASK_A};
      8'd47: v = {1'b1, 6'd41, MASK_A};
      8'd66: v = {1'b1, 6'd47, MASK_A};
      8'd93: v = {1'b1, 6'd39, MASK_A};
      8'd54: v = {1'b1, 6'd32, MASK_B};
      8'd55: v = {1'b1, 6'd33, MASK_B};
      8'd56: v = {1'b1, 6'd34, MASK_B};
      8'd83: v = {1'b1, 6'd31, MASK_B};
      8'd51: v = {1'b1, 6'd28, MASK_C};
      8'd59: v = {1'b1, 6'd29, MASK_C};
      8'd60: v = {1'b1, 6'd30, MASK_C};
      8'd120: v = {1'b1, 6'd19, MASK_D};
      8'd121: v = {1'b1, 6'd18, MASK_D};
      8'd124, 8'd77, 8'd80, 8'd81, 8'd98: v = {1'b1, 6'd15, MASK_D};
      8'd20: v = {1'b1, 6'd16, MASK_D};
      8'd21: v = {1'b1, 6'd21, MASK_D};
      8'd22: v = {1'b1, 6'd17, MASK_D};
      8'd69: v = {1'b1, 6'd20, MASK_D};
      8'd116: v = {1'b1, 6'd12, MASK_E};
      8'd117: v = {1'b1, 6'd13, MASK_E};
      8'd5, 8'd61: v = {1'b1, 6'd11, MASK_E};
      8'd101: v = {1'b1, 6'd14, MASK_F};
      8'd106: v = {1'b1, 6'd4, L_EOF};
      8'd122: v = {1'b1, 6'd5, L_RP};
      8'd123: v = {1'b1, 6'd6, L_RP};
      8'd127: v = {1'b1, 6'd8, L_RP};
      8'd15: v = {1'b1, 6'd7, L_RP};
      8'd16: v = {1'b1, 6'd1, L_EOF};
      8'd17: v = {1'b1, 6'd9, L_ID};
      8'd28: v = {1'b1, 6'd2, L_EOF};
      8'd38: v = {1'b1, 6'd44, L_RP};
      8'd41: v = {1'b1, 6'd3, L_INT};
      8'd65: v = {1'b1, 6'd45, L_RP};
      8'd87: v = {1'b1, 6'd22, L_RP};
      8'd88: v = {1'b1, 6'd23, L_RP};
      8'd89: v = {1'b1, 6'd24, L_RP};
      8'd90: v = {1'b1, 6'd25, L_RP};
      8'd91: v = {1'b1, 6'd26, L_RP};
      8'd92: v = {1'b1, 6'd27, L_RP};
      8'd95: v = {1'b1, 6'd10, L_ID};
      default: v = '0;
    endcase
    return v;
  endfunction

  // individual transitions: {hit, target}
  function automatic logic [8:0] edge_info(input logic [7:0] st, input logic [5:0] sy);
    logic [8:0] v;
    v = '0;
    unique case ({st, sy})
      {8'd1, N_EXPR}: v = {1'b1, 8'd86};
      {8'd102, N_EXPR}: v = {1'b1, 8'd11};
      {8'd104, N_EXPR}: v = {1'b1, 8'd72};
      {8'd14, N_EXPR}: v = {1'b1, 8'd88};
      {8'd27, N_EXPR}: v = {1'b1, 8'd89};
      {8'd34, N_EXPR}: v = {1'b1, 8'd90};
      {8'd37, N_EXPR}: v = {1'b1, 8'd91};
      {8'd40, N_EXPR}: v = {1'b1, 8'd87};
      {8'd46, N_EXPR}: v = {1'b1, 8'd92};
      {8'd52, N_EXPR}: v = {1'b1, 8'd64};
      {8'd79, N_EXPR}: v = {1'b1, 8'd85};
      {8'd9, N_EXPR}: v = {1'b1, 8'd71};
      {8'd97, N_EXPR}: v = {1'b1, 8'd70};
      {8'd103, S_RPAREN}: v = {1'b1, 8'd44};
      {8'd103, N_ARGS}: v = {1'b1, 8'd125};
      {8'd103, N_EXPR}: v = {1'b1, 8'd38};
      {8'd118, N_ARGS}: v = {1'b1, 8'd65};
      {8'd118, N_EXPR}: v = {1'b1, 8'd38};
      {8'd7, N_EXPR}: v = {1'b1, 8'd100};
      {8'd7, N_TEST}: v = {1'b1, 8'd49};
      {8'd8, N_EXPR}: v = {1'b1, 8'd100};
      {8'd8, N_TEST}: v = {1'b1, 8'd50};
      {8'd105, N_FACTOR}: v = {1'b1, 8'd55};
      {8'd111, N_FACTOR}: v = {1'b1, 8'd54};
      {8'd6, N_FACTOR}: v = {1'b1, 8'd26};
      {8'd67, N_FACTOR}: v = {1'b1, 8'd56};
      {8'd73, N_FACTOR}: v = {1'b1, 8'd66};
      {8'd3, N_FACTOR}: v = {1'b1, 8'd83};
      {8'd3, N_TERM}: v = {1'b1, 8'd60};
      {8'd74, N_FACTOR}: v = {1'b1, 8'd83};
      {8'd74, N_TERM}: v = {1'b1, 8'd59};
      {8'd108, S_RBRACE}: v = {1'b1, 8'd119};
      {8'd109, S_RBRACE}: v = {1'b1, 8'd120};
      {8'd110, S_RBRACE}: v = {1'b1, 8'd121};
      {8'd29, S_RETURN}: v = {1'b1, 8'd102};
      {8'd42, S_RETURN}: v = {1'b1, 8'd52};
      {8'd35, N_LVAL}: v = {1'b1, 8'd93};
      {8'd4, N_LVAL}: v = {1'b1, 8'd94};
      {8'd100, S_EQ}: v = {1'b1, 8'd40};
      {8'd100, S_GE}: v = {1'b1, 8'd37};
      {8'd100, S_GT}: v = {1'b1, 8'd46};
      {8'd100, S_LE}: v = {1'b1, 8'd34};
      {8'd100, S_LT}: v = {1'b1, 8'd27};
      {8'd100, S_NE}: v = {1'b1, 8'd14};
      {8'd11, S_SEMI}: v = {1'b1, 8'd23};
      {8'd38, S_COMMA}: v = {1'b1, 8'd118};
      {8'd64, S_SEMI}: v = {1'b1, 8'd39};
      {8'd70, S_SEMI}: v = {1'b1, 8'd22};
      {8'd71, S_RPAREN}: v = {1'b1, 8'd114};
      {8'd72, S_SEMI}: v = {1'b1, 8'd21};
      {8'd85, S_RBRACK}: v = {1'b1, 8'd47};
      {8'd86, S_RPAREN}: v = {1'b1, 8'd112};
      {8'd115, N_PROCS}: v = {1'b1, 8'd16};
      {8'd45, N_PROCS}: v = {1'b1, 8'd129};
      {8'd122, N_DCL}: v = {1'b1, 8'd15};
      {8'd122, N_PLIST}: v = {1'b1, 8'd123};
      {8'd122, N_PARAMS}: v = {1'b1, 8'd18};
      {8'd124, N_DCL}: v = {1'b1, 8'd63};
      {8'd124, N_STMTS}: v = {1'b1, 8'd42};
      {8'd84, N_DCL}: v = {1'b1, 8'd75};
      {8'd96, N_DCL}: v = {1'b1, 8'd76};
      {8'd98, N_DCL}: v = {1'b1, 8'd63};
      {8'd98, N_STMTS}: v = {1'b1, 8'd29};
      {8'd99, N_DCL}: v = {1'b1, 8'd15};
      {8'd99, N_PLIST}: v = {1'b1, 8'd127};
      {8'd0, S_BOF}: v = {1'b1, 8'd45};
      {8'd113, S_LBRACE}: v = {1'b1, 8'd77};
      {8'd114, S_SEMI}: v = {1'b1, 8'd69};
      {8'd119, S_ELSE}: v = {1'b1, 8'd113};
      {8'd12, S_BECOMES}: v = {1'b1, 8'd97};
      {8'd125, S_RPAREN}: v = {1'b1, 8'd24};
      {8'd126, S_LBRACK}: v = {1'b1, 8'd79};
      {8'd128, S_LPAREN}: v = {1'b1, 8'd84};
      {8'd129, S_EOF}: v = {1'b1, 8'd107};
      {8'd13, S_LPAREN}: v = {1'b1, 8'd103};
      {8'd131, S_LPAREN}: v = {1'b1, 8'd122};
      {8'd15, S_COMMA}: v = {1'b1, 8'd99};
      {8'd17, S_STAR}: v = {1'b1, 8'd95};
      {8'd18, S_RPAREN}: v = {1'b1, 8'd36};
      {8'd2, S_LPAREN}: v = {1'b1, 8'd9};
      {8'd23, S_RBRACE}: v = {1'b1, 8'd41};
      {8'd25, S_LBRACE}: v = {1'b1, 8'd61};
      {8'd30, S_INT}: v = {1'b1, 8'd126};
      {8'd31, S_LBRACE}: v = {1'b1, 8'd80};
      {8'd32, S_LBRACE}: v = {1'b1, 8'd81};
      {8'd36, S_LBRACE}: v = {1'b1, 8'd5};
      {8'd39, S_RBRACE}: v = {1'b1, 8'd106};
      {8'd43, S_LPAREN}: v = {1'b1, 8'd8};
      {8'd48, S_ID}: v = {1'b1, 8'd101};
      {8'd49, S_RPAREN}: v = {1'b1, 8'd31};
      {8'd5, N_DCLS}: v = {1'b1, 8'd98};
      {8'd50, S_RPAREN}: v = {1'b1, 8'd32};
      {8'd53, S_LPAREN}: v = {1'b1, 8'd7};
      {8'd57, S_LBRACK}: v = {1'b1, 8'd78};
      {8'd58, S_SEMI}: v = {1'b1, 8'd117};
      {8'd61, N_DCLS}: v = {1'b1, 8'd124};
      {8'd62, S_NULL}: v = {1'b1, 8'd58};
      {8'd62, S_NUM}: v = {1'b1, 8'd82};
      {8'd63, S_BECOMES}: v = {1'b1, 8'd62};
      {8'd68, S_ID}: v = {1'b1, 8'd131};
      {8'd68, S_WAIN}: v = {1'b1, 8'd128};
      {8'd75, S_COMMA}: v = {1'b1, 8'd96};
      {8'd76, S_RPAREN}: v = {1'b1, 8'd25};
      {8'd77, N_STMTS}: v = {1'b1, 8'd110};
      {8'd78, S_RBRACK}: v = {1'b1, 8'd104};
      {8'd80, N_STMTS}: v = {1'b1, 8'd108};
      {8'd81, N_STMTS}: v = {1'b1, 8'd109};
      {8'd82, S_SEMI}: v = {1'b1, 8'd116};
      {8'd94, S_RPAREN}: v = {1'b1, 8'd130};
      default: v = '0;
    endcase
    return v;
  endfunction

  // shared transition group of a state: {valid, group}
  function automatic logic [3:0] grp_of(input logic [7:0] st);
    logic [3:0] v;
    v = '0;
    unique case (st)
      8'd105, 8'd111, 8'd6, 8'd67, 8'd73, 8'd3, 8'd74: v = {1'b1, 3'd0};
      8'd1, 8'd102, 8'd104, 8'd14, 8'd27, 8'd34, 8'd37, 8'd40, 8'd46, 8'd52,
      8'd79, 8'd9, 8'd97, 8'd103, 8'd118, 8'd7, 8'd8: v = {1'b1, 3'd1};
      8'd108, 8'd109, 8'd110, 8'd29, 8'd42: v = {1'b1, 3'd2};
      8'd35, 8'd4: v = {1'b1, 3'd3};
      8'd100, 8'd11, 8'd38, 8'd64, 8'd70, 8'd71, 8'd72, 8'd85, 8'd86, 8'd87,
      8'd88, 8'd89, 8'd90, 8'd91, 8'd92: v = {1'b1, 3'd4};
      8'd51, 8'd59, 8'd60: v = {1'b1, 3'd5};
      8'd115, 8'd45: v = {1'b1, 3'd6};
      8'd122, 8'd124, 8'd84, 8'd96, 8'd98, 8'd99: v = {1'b1, 3'd7};
      default: v = '0;
    endcase
    return v;
  endfunction

  // group transitions: {hit, target}
  function automatic logic [8:0] grp_info(input logic [2:0] g, input logic [5:0] sy);
    logic [8:0] v;
    v = '0;
    unique case (g)
      3'd0, 3'd1: begin
        unique case (sy)
          S_AMP: v = {1'b1, 8'd35};
          S_ID: v = {1'b1, 8'd13};
          S_LPAREN: v = {1'b1, 8'd1};
          S_NEW: v = {1'b1, 8'd30};
          S_NULL: v = {1'b1, 8'd33};
          S_NUM: v = {1'b1, 8'd10};
          S_STAR: v = {1'b1, 8'd6};
          N_FACTOR: v = {(g == 3'd1), 8'd83};
          N_TERM: v = {(g == 3'd1), 8'd51};
          default: v = '0;
        endcase
      end
      3'd2, 3'd3: begin
        unique case (sy)
          S_ID: v = {1'b1, 8'd19};
          S_LPAREN: v = {1'b1, 8'd4};
          S_STAR: v = {1'b1, 8'd73};
          S_DELETE: v = {(g == 3'd2), 8'd57};
          S_IF: v = {(g == 3'd2), 8'd53};
          S_PRINTLN: v = {(g == 3'd2), 8'd2};
          S_WHILE: v = {(g == 3'd2), 8'd43};
          N_LVAL: v = {(g == 3'd2), 8'd12};
          N_STMT: v = {(g == 3'd2), 8'd20};
          default: v = '0;
        endcase
      end
      3'd4: begin
        unique case (sy)
          S_MINUS: v = {1'b1, 8'd3};
          S_PLUS: v = {1'b1, 8'd74};
          default: v = '0;
        endcase
      end
      3'd5: begin
        unique case (sy)
          S_PCT: v = {1'b1, 8'd67};
          S_SLASH: v = {1'b1, 8'd105};
          S_STAR: v = {1'b1, 8'd111};
          default: v = '0;
        endcase
      end
      3'd6: begin
        unique case (sy)
          S_INT: v = {1'b1, 8'd68};
          N_MAIN: v = {1'b1, 8'd28};
          N_PROC: v = {1'b1, 8'd115};
          default: v = '0;
        endcase
      end
      3'd7: begin
        unique case (sy)
          S_INT: v = {1'b1, 8'd17};
          N_TYPE: v = {1'b1, 8'd48};
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // action table entry: reduction wins over transitions, single edges over groups
  function automatic logic [7:0] act_lookup(input logic [7:0] st, input logic [5:0] sy);
    logic [41:0] rd;
    logic [8:0]  ed;
    logic [3:0]  gp;
    logic [8:0]  gi;
    logic [7:0]  v;
    rd = red_info(st);
    ed = edge_info(st, sy);
    gp = grp_of(st);
    gi = grp_info(gp[2:0], sy);
    v  = ACT_NONE;
    if (rd[41] && (sy < NUM_TERM) && (((rd[34:0] >> sy) & 35'd1) != 35'd0)) begin
      v = ACT_RED + {2'b00, rd[40:35]};
    end else if (ed[8]) begin
      v = ed[7:0];
    end else if (gp[3] && gi[8]) begin
      v = gi[7:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/slr_act_rom.sv */
// ---------------------------------------------------------------------------
// SLR action table
// Read-only action/goto table, one lookup per cycle, registered output.
// ---------------------------------------------------------------------------
`default_nettype none

module slr_act_rom (
  input  wire logic       clk,
  input  wire logic [7:0] rd_state,
  input  wire logic [5:0] rd_sym,
  output logic      [7:0] rd_act
);

  logic [7:0] act_r;

  always_ff @(posedge clk) begin
    act_r <= slr_pkg::act_lookup(rd_state, rd_sym);
  end

  assign rd_act = act_r;

endmodule

`default_nettype wire

/* rtl/slr_shift_reduce_parser.sv */
// ---------------------------------------------------------------------------
// SLR(1) shift-reduce parser
// Table-driven parser driver: one token word in, one or more event words out.
// ---------------------------------------------------------------------------
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_stall, in_token_kind             | in
//  out     | out_valid, out_stall, out_event_res,          | out
//          | out_rule_number, out_new_state,               |
//          | out_stack_depth, out_last                     |
//
//  A token is shifted after an action lookup, and each reduction it triggers
//  runs the loop action lookup -> stack read -> goto lookup -> push.
//  EOF adds an accept word; an error found mid-token adds an error word.
//  Tokens after an error, or with an unknown code, give only an error word.
//  Synchronous active-low reset; the stack holds state 0 and no error.
//  in_stall is high while a token is being worked on; a stalled output
//  word holds the sequencer in its emitting state.
// ---------------------------------------------------------------------------
`default_nettype none

module slr_shift_reduce_parser #(
  parameter int STACK_DEPTH = slr_pkg::STACK_DEPTH_DEF,
  parameter int MAX_CHAIN   = slr_pkg::MAX_CHAIN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [5:0] in_token_kind,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_event_res,
  output logic      [5:0] out_rule_number,
  output logic      [7:0] out_new_state,
  output logic      [8:0] out_stack_depth,
  output logic            out_last
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_CHAIN);

  // sequencer and stack bookkeeping
  slr_pkg::slr_state_t state_r, state_nxt;
  logic [5:0]     kind_r, kind_nxt;
  logic [7:0]     top_r, top_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           err_r, err_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [5:0]     rule_r, rule_nxt;
  logic [4:0]     head_r, head_nxt;
  logic [SPW-1:0] spn_r, spn_nxt;

  // output word register
  logic       ov_r, ov_nxt;
  logic [1:0] oev_r, oev_nxt;
  logic [5:0] orule_r, orule_nxt;
  logic [7:0] ons_r, ons_nxt;
  logic [8:0] odep_r, odep_nxt;
  logic       olast_r, olast_nxt;

  // state stack memory; entry 0 is never written and always reads as state 0
  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [7:0]    rd_q_r;
  logic          rd_zero_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;

  // action table port
  logic [7:0] rom_state, rom_act;
  logic [5:0] rom_sym;

  // decode helpers
  logic           out_free, is_red;
  logic [8:0]     rinfo;
  logic [SPW-1:0] len_ext, rda_full, spn_calc;
  logic [7:0]     pop_state;

  // check terms
  logic acc_word, in_take, start_ok;

  slr_act_rom u_rom (
    .clk      (clk),
    .rd_state (rom_state),
    .rd_sym   (rom_sym),
    .rd_act   (rom_act)
  );

  assign out_free  = !ov_r || !out_stall;
  assign pop_state = rd_zero_r ? 8'd0 : rd_q_r;
  assign is_red    = (rom_act >= slr_pkg::ACT_RED) && (rom_act != slr_pkg::ACT_NONE);
  assign rinfo     = slr_pkg::rule_info(rom_act[5:0]);
  assign len_ext   = {{(SPW-4){1'b0}}, rinfo[8:5]};
  assign spn_calc  = sp_r - len_ext;
  assign rda_full  = spn_calc - {{(SPW-1){1'b0}}, 1'b1};

  // goto lookup uses the popped-to state; everything else the live top
  always_comb begin
    if (state_r == slr_pkg::ST_POP || state_r == slr_pkg::ST_GOTO) begin
      rom_state = pop_state;
      rom_sym   = slr_pkg::NUM_TERM + {1'b0, head_r};
    end else begin
      rom_state = top_r;
      rom_sym   = kind_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    top_nxt   = top_r;
    sp_nxt    = sp_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    rule_nxt  = rule_r;
    head_nxt  = head_r;
    spn_nxt   = spn_r;
    rd_en     = 1'b0;
    rd_addr   = rda_full[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = sp_r[AW-1:0];
    wr_data   = rom_act;
    ov_nxt    = ov_r && out_stall;
    oev_nxt   = oev_r;
    orule_nxt = orule_r;
    ons_nxt   = ons_r;
    odep_nxt  = odep_r;
    olast_nxt = olast_r;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_token_kind;
          cnt_nxt  = '0;
          if (err_r || in_token_kind >= slr_pkg::NUM_TERM) begin
            state_nxt = slr_pkg::ST_ERR;
          end else begin
            state_nxt = slr_pkg::ST_LOOK;
          end
        end
      end
      slr_pkg::ST_LOOK: begin
        state_nxt = slr_pkg::ST_ACT;
      end
      slr_pkg::ST_ACT: begin
        if (is_red) begin
          priority if (cnt_r >= CW'(MAX_CHAIN - 2)) begin
            state_nxt = slr_pkg::ST_ERR;
          end else if (rom_act[5:0] >= slr_pkg::NUM_RULES) begin
            state_nxt = slr_pkg::ST_ERR;
          end else if (len_ext >= sp_r) begin
            state_nxt = slr_pkg::ST_ERR;
          end else begin
            rd_en     = 1'b1;
            rule_nxt  = rom_act[5:0];
            head_nxt  = rinfo[4:0];
            spn_nxt   = spn_calc;
            state_nxt = slr_pkg::ST_POP;
          end
        end else if (rom_act >= slr_pkg::NUM_STATES || sp_r >= SPW'(STACK_DEPTH)) begin
          state_nxt = slr_pkg::ST_ERR;
        end else if (out_free) begin
          // shift
          wr_en     = 1'b1;
          top_nxt   = rom_act;
          sp_nxt    = sp_r + 1'b1;
          ov_nxt    = 1'b1;
          oev_nxt   = slr_pkg::EV_SHIFT;
          orule_nxt = '0;
          ons_nxt   = rom_act;
          odep_nxt  = 9'(sp_r + 1'b1);
          olast_nxt = (kind_r != slr_pkg::S_EOF);
          state_nxt = (kind_r == slr_pkg::S_EOF) ? slr_pkg::ST_ACC : slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_POP: begin
        state_nxt = slr_pkg::ST_GOTO;
      end
      slr_pkg::ST_GOTO: begin
        if (rom_act >= slr_pkg::NUM_STATES || spn_r >= SPW'(STACK_DEPTH)) begin
          state_nxt = slr_pkg::ST_ERR;
        end else if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = spn_r[AW-1:0];
          top_nxt   = rom_act;
          sp_nxt    = spn_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ov_nxt    = 1'b1;
          oev_nxt   = slr_pkg::EV_REDUCE;
          orule_nxt = rule_r;
          ons_nxt   = rom_act;
          odep_nxt  = 9'(spn_r + 1'b1);
          olast_nxt = 1'b0;
          state_nxt = slr_pkg::ST_LOOK;
        end
      end
      slr_pkg::ST_ACC: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oev_nxt   = slr_pkg::EV_ACCEPT;
          orule_nxt = '0;
          ons_nxt   = top_r;
          odep_nxt  = 9'(sp_r);
          olast_nxt = 1'b1;
          state_nxt = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_ERR: begin
        if (out_free) begin
          err_nxt   = 1'b1;
          ov_nxt    = 1'b1;
          oev_nxt   = slr_pkg::EV_ERROR;
          orule_nxt = '0;
          ons_nxt   = top_r;
          odep_nxt  = 9'(sp_r);
          olast_nxt = 1'b1;
          state_nxt = slr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slr_pkg::ST_IDLE;
      top_r   <= 8'd0;
      sp_r    <= {{(SPW-1){1'b0}}, 1'b1};
      err_r   <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    rule_r  <= rule_nxt;
    head_r  <= head_nxt;
    spn_r   <= spn_nxt;
    oev_r   <= oev_nxt;
    orule_r <= orule_nxt;
    ons_r   <= ons_nxt;
    odep_r  <= odep_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= stack_mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  assign in_stall        = (state_r != slr_pkg::ST_IDLE);
  assign out_valid       = ov_r;
  assign out_event_res   = oev_r;
  assign out_rule_number = orule_r;
  assign out_new_state   = ons_r;
  assign out_stack_depth = odep_r;
  assign out_last        = olast_r;

  assign acc_word = out_valid && (out_event_res == slr_pkg::EV_ACCEPT);
  assign in_take  = in_valid && !in_stall;
  assign start_ok = (state_r == slr_pkg::ST_LOOK) || (state_r == slr_pkg::ST_ERR);

`include "slr_shift_reduce_parser_assert.svh"

  `SLR_ASSERT_NEXT(a_err_sticky, err_r, err_r, "error flag cleared")
  `SLR_ASSERT_ALWAYS(a_sp_range, (sp_r != '0) && (sp_r <= SPW'(STACK_DEPTH)), "sp range")
  `SLR_ASSERT_SAME(a_acc_last, acc_word, out_last, "accept not last")
  `SLR_ASSERT_NEXT(a_take, in_take, start_ok, "bad start")

endmodule

`default_nettype wire

/* tb/sv/slr_shift_reduce_parser_tb.sv */
// ---------------------------------------------------------------------------
// SLR(1) shift-reduce parser testbench
// Feeds one long, well-formed random program (BOF .. EOF) with every
// statement kind and comparison, then tokens after accept, unknown codes and random
// noise. A local parser model with its own action table predicts every event
// word, and each word that comes out is checked against it.
// ---------------------------------------------------------------------------
`default_nettype none

module slr_shift_reduce_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_SIZE  = 256;
  localparam int CHAIN_LIMIT = 64;
  localparam int IDLE_LIMIT  = 5000;

  typedef struct {
    slr_pkg::slr_event_t ev;
    logic [5:0] rule;
    logic [7:0] st;
    logic [8:0] depth;
    logic       last;
  } parse_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [5:0] in_token_kind;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_event_res;
  logic [5:0] out_rule_number;
  logic [7:0] out_new_state;
  logic [8:0] out_stack_depth;
  logic       out_last;

  slr_shift_reduce_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_token_kind(in_token_kind),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(out_event_res), .out_rule_number(out_rule_number),
    .out_new_state(out_new_state), .out_stack_depth(out_stack_depth),
    .out_last(out_last)
  );

  // model state: action table, rule shapes, parse stack, sticky error
  logic [7:0]  act_tab [0:136*64-1];
  int          rule_len  [0:48];
  int          rule_head [0:48];
  logic [7:0]  parse_stack [0:STACK_SIZE-1];
  int          parse_sp;
  bit          parse_err;

  parse_word_t events_due[$];
  parse_word_t pend;
  bit          have_pend;
  logic [5:0]  prog[$];

  int  fails;
  int  tokens_sent;
  int  words_seen;
  int  ev_count [0:3];
  int  idle_cycles;
  int  out_hold;
  bit  in_burst;
  bit  out_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- action table build ---------------------------------------------
  function automatic void put_act(int st, logic [5:0] sy, int to);
    act_tab[st*64 + sy] = to[7:0];
  endfunction

  // shared transition groups
  function automatic void add_grp(int st, int g);
    case (g)
      0, 1: begin
        put_act(st, slr_pkg::S_AMP, 35);    put_act(st, slr_pkg::S_ID, 13);
        put_act(st, slr_pkg::S_LPAREN, 1);  put_act(st, slr_pkg::S_NEW, 30);
        put_act(st, slr_pkg::S_NULL, 33);   put_act(st, slr_pkg::S_NUM, 10);
        put_act(st, slr_pkg::S_STAR, 6);
        if (g == 1) begin
          put_act(st, slr_pkg::N_FACTOR, 83); put_act(st, slr_pkg::N_TERM, 51);
        end
      end
      2, 3: begin
        put_act(st, slr_pkg::S_ID, 19);     put_act(st, slr_pkg::S_LPAREN, 4);
        put_act(st, slr_pkg::S_STAR, 73);
        if (g == 2) begin
          put_act(st, slr_pkg::S_DELETE, 57); put_act(st, slr_pkg::S_IF, 53);
          put_act(st, slr_pkg::S_PRINTLN, 2); put_act(st, slr_pkg::S_WHILE, 43);
          put_act(st, slr_pkg::N_LVAL, 12);   put_act(st, slr_pkg::N_STMT, 20);
        end
      end
      4: begin
        put_act(st, slr_pkg::S_MINUS, 3); put_act(st, slr_pkg::S_PLUS, 74);
      end
      5: begin
        put_act(st, slr_pkg::S_PCT, 67); put_act(st, slr_pkg::S_SLASH, 105);
        put_act(st, slr_pkg::S_STAR, 111);
      end
      6: begin
        put_act(st, slr_pkg::S_INT, 68); put_act(st, slr_pkg::N_MAIN, 28);
        put_act(st, slr_pkg::N_PROC, 115);
      end
      default: begin
        put_act(st, slr_pkg::S_INT, 17); put_act(st, slr_pkg::N_TYPE, 48);
      end
    endcase
  endfunction

  function automatic void add_red(int st, int rule, logic [34:0] look);
    for (int j = 0; j < 35; j++)
      if (look[j]) act_tab[st*64 + j] = slr_pkg::ACT_RED + rule[7:0];
  endfunction

  function automatic void build_tables();
    for (int i = 0; i < 136*64; i++) act_tab[i] = slr_pkg::ACT_NONE;
    rule_len = '{3,2,1,12,14,0,1,1,3,1,2,0,5,5,2,0,2,4,11,7,5,5,3,3,3,3,3,3,1,3,3,
                 1,3,3,3,1,1,1,3,2,2,5,3,4,1,3,1,2,3};
    rule_head[0] = slr_pkg::N_START;  rule_head[1] = slr_pkg::N_PROCS;
    rule_head[2] = slr_pkg::N_PROCS;  rule_head[3] = slr_pkg::N_PROC;
    rule_head[4] = slr_pkg::N_MAIN;   rule_head[5] = slr_pkg::N_PARAMS;
    rule_head[6] = slr_pkg::N_PARAMS; rule_head[7] = slr_pkg::N_PLIST;
    rule_head[8] = slr_pkg::N_PLIST;  rule_head[9] = slr_pkg::N_TYPE;
    rule_head[10] = slr_pkg::N_TYPE;
    for (int r = 11; r <= 13; r++) rule_head[r] = slr_pkg::N_DCLS;
    rule_head[14] = slr_pkg::N_DCL;
    rule_head[15] = slr_pkg::N_STMTS; rule_head[16] = slr_pkg::N_STMTS;
    for (int r = 17; r <= 21; r++) rule_head[r] = slr_pkg::N_STMT;
    for (int r = 22; r <= 27; r++) rule_head[r] = slr_pkg::N_TEST;
    for (int r = 28; r <= 30; r++) rule_head[r] = slr_pkg::N_EXPR;
    for (int r = 31; r <= 34; r++) rule_head[r] = slr_pkg::N_TERM;
    for (int r = 35; r <= 43; r++) rule_head[r] = slr_pkg::N_FACTOR;
    rule_head[44] = slr_pkg::N_ARGS;  rule_head[45] = slr_pkg::N_ARGS;
    for (int r = 46; r <= 48; r++) rule_head[r] = slr_pkg::N_LVAL;

    add_grp(105,0); add_grp(111,0); add_grp(6,0); add_grp(67,0); add_grp(73,0);
    add_grp(3,0);   add_grp(74,0);
    add_grp(1,1);   add_grp(102,1); add_grp(104,1); add_grp(14,1); add_grp(27,1);
    add_grp(34,1);  add_grp(37,1);  add_grp(40,1);  add_grp(46,1); add_grp(52,1);
    add_grp(79,1);  add_grp(9,1);   add_grp(97,1);  add_grp(103,1); add_grp(118,1);
    add_grp(7,1);   add_grp(8,1);
    add_grp(108,2); add_grp(109,2); add_grp(110,2); add_grp(29,2); add_grp(42,2);
    add_grp(35,3);  add_grp(4,3);
    add_grp(100,4); add_grp(11,4);  add_grp(38,4);  add_grp(64,4); add_grp(70,4);
    add_grp(71,4);  add_grp(72,4);  add_grp(85,4);  add_grp(86,4); add_grp(87,4);
    add_grp(88,4);  add_grp(89,4);  add_grp(90,4);  add_grp(91,4); add_grp(92,4);
    add_grp(51,5);  add_grp(59,5);  add_grp(60,5);
    add_grp(115,6); add_grp(45,6);
    add_grp(122,7); add_grp(124,7); add_grp(84,7); add_grp(96,7); add_grp(98,7);
    add_grp(99,7);

    // single transitions override the groups
    put_act(1, slr_pkg::N_EXPR, 86);    put_act(102, slr_pkg::N_EXPR, 11);
    put_act(104, slr_pkg::N_EXPR, 72);  put_act(14, slr_pkg::N_EXPR, 88);
    put_act(27, slr_pkg::N_EXPR, 89);   put_act(34, slr_pkg::N_EXPR, 90);
    put_act(37, slr_pkg::N_EXPR, 91);   put_act(40, slr_pkg::N_EXPR, 87);
    put_act(46, slr_pkg::N_EXPR, 92);   put_act(52, slr_pkg::N_EXPR, 64);
    put_act(79, slr_pkg::N_EXPR, 85);   put_act(9, slr_pkg::N_EXPR, 71);
    put_act(97, slr_pkg::N_EXPR, 70);   put_act(103, slr_pkg::S_RPAREN, 44);
    put_act(103, slr_pkg::N_ARGS, 125); put_act(103, slr_pkg::N_EXPR, 38);
    put_act(118, slr_pkg::N_ARGS, 65);  put_act(118, slr_pkg::N_EXPR, 38);
    put_act(7, slr_pkg::N_EXPR, 100);   put_act(7, slr_pkg::N_TEST, 49);
    put_act(8, slr_pkg::N_EXPR, 100);   put_act(8, slr_pkg::N_TEST, 50);
    put_act(105, slr_pkg::N_FACTOR, 55); put_act(111, slr_pkg::N_FACTOR, 54);
    put_act(6, slr_pkg::N_FACTOR, 26);   put_act(67, slr_pkg::N_FACTOR, 56);
    put_act(73, slr_pkg::N_FACTOR, 66);  put_act(3, slr_pkg::N_FACTOR, 83);
    put_act(3, slr_pkg::N_TERM, 60);     put_act(74, slr_pkg::N_FACTOR, 83);
    put_act(74, slr_pkg::N_TERM, 59);
    put_act(108, slr_pkg::S_RBRACE, 119); put_act(109, slr_pkg::S_RBRACE, 120);
    put_act(110, slr_pkg::S_RBRACE, 121);
    put_act(29, slr_pkg::S_RETURN, 102);  put_act(42, slr_pkg::S_RETURN, 52);
    put_act(35, slr_pkg::N_LVAL, 93);     put_act(4, slr_pkg::N_LVAL, 94);
    put_act(100, slr_pkg::S_EQ, 40); put_act(100, slr_pkg::S_GE, 37);
    put_act(100, slr_pkg::S_GT, 46); put_act(100, slr_pkg::S_LE, 34);
    put_act(100, slr_pkg::S_LT, 27); put_act(100, slr_pkg::S_NE, 14);
    put_act(11, slr_pkg::S_SEMI, 23);    put_act(38, slr_pkg::S_COMMA, 118);
    put_act(64, slr_pkg::S_SEMI, 39);    put_act(70, slr_pkg::S_SEMI, 22);
    put_act(71, slr_pkg::S_RPAREN, 114); put_act(72, slr_pkg::S_SEMI, 21);
    put_act(85, slr_pkg::S_RBRACK, 47);  put_act(86, slr_pkg::S_RPAREN, 112);
    put_act(115, slr_pkg::N_PROCS, 16);  put_act(45, slr_pkg::N_PROCS, 129);
    put_act(122, slr_pkg::N_DCL, 15);    put_act(122, slr_pkg::N_PLIST, 123);
    put_act(122, slr_pkg::N_PARAMS, 18); put_act(124, slr_pkg::N_DCL, 63);
    put_act(124, slr_pkg::N_STMTS, 42);  put_act(84, slr_pkg::N_DCL, 75);
    put_act(96, slr_pkg::N_DCL, 76);     put_act(98, slr_pkg::N_DCL, 63);
    put_act(98, slr_pkg::N_STMTS, 29);   put_act(99, slr_pkg::N_DCL, 15);
    put_act(99, slr_pkg::N_PLIST, 127);
    put_act(0, slr_pkg::S_BOF, 45);       put_act(113, slr_pkg::S_LBRACE, 77);
    put_act(114, slr_pkg::S_SEMI, 69);    put_act(119, slr_pkg::S_ELSE, 113);
    put_act(12, slr_pkg::S_BECOMES, 97);  put_act(125, slr_pkg::S_RPAREN, 24);
    put_act(126, slr_pkg::S_LBRACK, 79);  put_act(128, slr_pkg::S_LPAREN, 84);
    put_act(129, slr_pkg::S_EOF, 107);    put_act(13, slr_pkg::S_LPAREN, 103);
    put_act(131, slr_pkg::S_LPAREN, 122); put_act(15, slr_pkg::S_COMMA, 99);
    put_act(17, slr_pkg::S_STAR, 95);     put_act(18, slr_pkg::S_RPAREN, 36);
    put_act(2, slr_pkg::S_LPAREN, 9);     put_act(23, slr_pkg::S_RBRACE, 41);
    put_act(25, slr_pkg::S_LBRACE, 61);   put_act(30, slr_pkg::S_INT, 126);
    put_act(31, slr_pkg::S_LBRACE, 80);   put_act(32, slr_pkg::S_LBRACE, 81);
    put_act(36, slr_pkg::S_LBRACE, 5);    put_act(39, slr_pkg::S_RBRACE, 106);
    put_act(43, slr_pkg::S_LPAREN, 8);    put_act(48, slr_pkg::S_ID, 101);
    put_act(49, slr_pkg::S_RPAREN, 31);   put_act(5, slr_pkg::N_DCLS, 98);
    put_act(50, slr_pkg::S_RPAREN, 32);   put_act(53, slr_pkg::S_LPAREN, 7);
    put_act(57, slr_pkg::S_LBRACK, 78);   put_act(58, slr_pkg::S_SEMI, 117);
    put_act(61, slr_pkg::N_DCLS, 124);    put_act(62, slr_pkg::S_NULL, 58);
    put_act(62, slr_pkg::S_NUM, 82);      put_act(63, slr_pkg::S_BECOMES, 62);
    put_act(68, slr_pkg::S_ID, 131);      put_act(68, slr_pkg::S_WAIN, 128);
    put_act(75, slr_pkg::S_COMMA, 96);    put_act(76, slr_pkg::S_RPAREN, 25);
    put_act(77, slr_pkg::N_STMTS, 110);   put_act(78, slr_pkg::S_RBRACK, 104);
    put_act(80, slr_pkg::N_STMTS, 108);   put_act(81, slr_pkg::N_STMTS, 109);
    put_act(82, slr_pkg::S_SEMI, 116);    put_act(94, slr_pkg::S_RPAREN, 130);

    // reductions win over everything on their lookahead
    add_red(10,36,slr_pkg::MASK_A);  add_red(112,38,slr_pkg::MASK_A);
    add_red(13,35,slr_pkg::MASK_A);  add_red(130,48,slr_pkg::MASK_A);
    add_red(19,46,slr_pkg::MASK_A);  add_red(24,43,slr_pkg::MASK_A);
    add_red(26,40,slr_pkg::MASK_A);  add_red(33,37,slr_pkg::MASK_A);
    add_red(44,42,slr_pkg::MASK_A);  add_red(47,41,slr_pkg::MASK_A);
    add_red(66,47,slr_pkg::MASK_A);  add_red(93,39,slr_pkg::MASK_A);
    add_red(54,32,slr_pkg::MASK_B);  add_red(55,33,slr_pkg::MASK_B);
    add_red(56,34,slr_pkg::MASK_B);  add_red(83,31,slr_pkg::MASK_B);
    add_red(51,28,slr_pkg::MASK_C);  add_red(59,29,slr_pkg::MASK_C);
    add_red(60,30,slr_pkg::MASK_C);
    add_red(120,19,slr_pkg::MASK_D); add_red(121,18,slr_pkg::MASK_D);
    add_red(124,15,slr_pkg::MASK_D); add_red(20,16,slr_pkg::MASK_D);
    add_red(21,21,slr_pkg::MASK_D);  add_red(22,17,slr_pkg::MASK_D);
    add_red(69,20,slr_pkg::MASK_D);  add_red(77,15,slr_pkg::MASK_D);
    add_red(80,15,slr_pkg::MASK_D);  add_red(81,15,slr_pkg::MASK_D);
    add_red(98,15,slr_pkg::MASK_D);
    add_red(116,12,slr_pkg::MASK_E); add_red(117,13,slr_pkg::MASK_E);
    add_red(5,11,slr_pkg::MASK_E);   add_red(61,11,slr_pkg::MASK_E);
    add_red(101,14,slr_pkg::MASK_F);
    add_red(106,4,slr_pkg::L_EOF);  add_red(122,5,slr_pkg::L_RP);
    add_red(123,6,slr_pkg::L_RP);   add_red(127,8,slr_pkg::L_RP);
    add_red(15,7,slr_pkg::L_RP);    add_red(16,1,slr_pkg::L_EOF);
    add_red(17,9,slr_pkg::L_ID);    add_red(28,2,slr_pkg::L_EOF);
    add_red(38,44,slr_pkg::L_RP);   add_red(41,3,slr_pkg::L_INT);
    add_red(65,45,slr_pkg::L_RP);   add_red(87,22,slr_pkg::L_RP);
    add_red(88,23,slr_pkg::L_RP);   add_red(89,24,slr_pkg::L_RP);
    add_red(90,25,slr_pkg::L_RP);   add_red(91,26,slr_pkg::L_RP);
    add_red(92,27,slr_pkg::L_RP);   add_red(95,10,slr_pkg::L_ID);

    for (int i = 0; i < STACK_SIZE; i++) parse_stack[i] = 8'd0;
    parse_sp  = 1;
    parse_err = 1'b0;
  endfunction

  // ---- parse model ----------------------------------------------------
  // words are held back by one so the final word of a token gets last set
  function automatic void note_event(slr_pkg::slr_event_t ev, int rule);
    if (have_pend) events_due = {events_due, pend};
    pend.ev    = ev;
    pend.rule  = rule[5:0];
    pend.st    = parse_stack[parse_sp-1];
    pend.depth = parse_sp[8:0];
    pend.last  = 1'b0;
    have_pend  = 1'b1;
  endfunction

  function automatic void predict_token(logic [5:0] kind);
    int   top, rule, len, nsp, go, cnt;
    logic [7:0] a;
    bit   failed;
    cnt = 0;
    failed = 1'b0;
    have_pend = 1'b0;
    if (parse_err || kind >= slr_pkg::NUM_TERM) begin
      failed = 1'b1;
    end else begin
      forever begin
        top = parse_stack[parse_sp-1];
        a = act_tab[top*64 + kind];
        if (a < slr_pkg::ACT_RED || a == slr_pkg::ACT_NONE) break;
        rule = a - slr_pkg::ACT_RED;
        if (cnt >= CHAIN_LIMIT - 2 || rule >= 49 || rule_len[rule] >= parse_sp) begin
          failed = 1'b1;
          break;
        end
        len = rule_len[rule];
        nsp = parse_sp - len;
        go  = act_tab[parse_stack[nsp-1]*64 + rule_head[rule]];
        if (go >= slr_pkg::NUM_STATES || nsp >= STACK_SIZE) begin
          failed = 1'b1;
          break;
        end
        parse_stack[nsp] = go[7:0];
        parse_sp = nsp + 1;
        note_event(slr_pkg::EV_REDUCE, rule);
        cnt++;
      end
      if (!failed) begin
        if (a >= slr_pkg::NUM_STATES || parse_sp >= STACK_SIZE) begin
          failed = 1'b1;
        end else begin
          parse_stack[parse_sp] = a;
          parse_sp++;
          note_event(slr_pkg::EV_SHIFT, 0);
          if (kind == slr_pkg::S_EOF) note_event(slr_pkg::EV_ACCEPT, 0);
        end
      end
    end
    if (failed) begin
      parse_err = 1'b1;
      note_event(slr_pkg::EV_ERROR, 0);
    end
    pend.last = 1'b1;
    events_due = {events_due, pend};
  endfunction

  // ---- program generator ----------------------------------------------
  task automatic tok(logic [5:0] k);
    prog = {prog, k};
  endtask

  task automatic gen_factor(int d);
    int c;
    c = (d >= 3) ? $urandom_range(0, 2) : $urandom_range(0, 8);
    case (c)
      0: tok(slr_pkg::S_ID);
      1: tok(slr_pkg::S_NUM);
      2: tok(slr_pkg::S_NULL);
      3: begin tok(slr_pkg::S_LPAREN); gen_expr(d+1); tok(slr_pkg::S_RPAREN); end
      4: begin tok(slr_pkg::S_AMP); gen_lvalue(d+1); end
      5: begin tok(slr_pkg::S_STAR); gen_factor(d+1); end
      6: begin
        tok(slr_pkg::S_NEW); tok(slr_pkg::S_INT); tok(slr_pkg::S_LBRACK);
        gen_expr(d+1); tok(slr_pkg::S_RBRACK);
      end
      7: begin tok(slr_pkg::S_ID); tok(slr_pkg::S_LPAREN); tok(slr_pkg::S_RPAREN); end
      default: begin
        tok(slr_pkg::S_ID); tok(slr_pkg::S_LPAREN); gen_expr(d+1);
        repeat ($urandom_range(0, 2)) begin tok(slr_pkg::S_COMMA); gen_expr(d+1); end
        tok(slr_pkg::S_RPAREN);
      end
    endcase
  endtask

  task automatic gen_lvalue(int d);
    int c;
    c = (d >= 3) ? 0 : $urandom_range(0, 2);
    case (c)
      0: tok(slr_pkg::S_ID);
      1: begin tok(slr_pkg::S_STAR); gen_factor(d+1); end
      default: begin tok(slr_pkg::S_LPAREN); gen_lvalue(d+1); tok(slr_pkg::S_RPAREN); end
    endcase
  endtask

  task automatic gen_term(int d);
    int c;
    gen_factor(d);
    repeat ((d >= 3) ? 0 : $urandom_range(0, 2)) begin
      c = $urandom_range(0, 2);
      tok(c == 0 ? slr_pkg::S_STAR : (c == 1 ? slr_pkg::S_SLASH : slr_pkg::S_PCT));
      gen_factor(d);
    end
  endtask

  task automatic gen_expr(int d);
    gen_term(d+1);
    repeat ((d >= 3) ? 0 : $urandom_range(0, 2)) begin
      tok($urandom_range(0, 1) ? slr_pkg::S_PLUS : slr_pkg::S_MINUS);
      gen_term(d+1);
    end
  endtask

  task automatic gen_test(int d, int op);
    logic [5:0] ops [0:5];
    ops = '{slr_pkg::S_EQ, slr_pkg::S_NE, slr_pkg::S_LT, slr_pkg::S_LE,
            slr_pkg::S_GE, slr_pkg::S_GT};
    gen_expr(d);
    tok(ops[op % 6]);
    gen_expr(d);
  endtask

  task automatic gen_stmts(int d, int n);
    repeat (n) gen_stmt($urandom_range(0, 4), d);
  endtask

  task automatic gen_stmt(int kind, int d);
    int inner;
    inner = (d >= 2) ? 0 : $urandom_range(0, 2);
    case (kind)
      0: begin
        gen_lvalue(d); tok(slr_pkg::S_BECOMES); gen_expr(d); tok(slr_pkg::S_SEMI);
      end
      1: begin
        tok(slr_pkg::S_IF); tok(slr_pkg::S_LPAREN);
        gen_test(d, $urandom_range(0, 5)); tok(slr_pkg::S_RPAREN);
        tok(slr_pkg::S_LBRACE); gen_stmts(d+1, inner); tok(slr_pkg::S_RBRACE);
        tok(slr_pkg::S_ELSE);
        tok(slr_pkg::S_LBRACE); gen_stmts(d+1, inner); tok(slr_pkg::S_RBRACE);
      end
      2: begin
        tok(slr_pkg::S_WHILE); tok(slr_pkg::S_LPAREN);
        gen_test(d, $urandom_range(0, 5)); tok(slr_pkg::S_RPAREN);
        tok(slr_pkg::S_LBRACE); gen_stmts(d+1, inner); tok(slr_pkg::S_RBRACE);
      end
      3: begin
        tok(slr_pkg::S_PRINTLN); tok(slr_pkg::S_LPAREN); gen_expr(d);
        tok(slr_pkg::S_RPAREN); tok(slr_pkg::S_SEMI);
      end
      default: begin
        tok(slr_pkg::S_DELETE); tok(slr_pkg::S_LBRACK); tok(slr_pkg::S_RBRACK);
        gen_expr(d); tok(slr_pkg::S_SEMI);
      end
    endcase
  endtask

  task automatic gen_dcl();
    tok(slr_pkg::S_INT);
    if ($urandom_range(0, 1)) tok(slr_pkg::S_STAR);
    tok(slr_pkg::S_ID);
  endtask

  task automatic gen_dcls();
    repeat ($urandom_range(0, 3)) begin
      gen_dcl(); tok(slr_pkg::S_BECOMES);
      tok($urandom_range(0, 1) ? slr_pkg::S_NUM : slr_pkg::S_NULL);
      tok(slr_pkg::S_SEMI);
    end
  endtask

  task automatic gen_proc();
    tok(slr_pkg::S_INT); tok(slr_pkg::S_ID); tok(slr_pkg::S_LPAREN);
    if ($urandom_range(0, 2) != 0) begin
      gen_dcl();
      repeat ($urandom_range(0, 2)) begin tok(slr_pkg::S_COMMA); gen_dcl(); end
    end
    tok(slr_pkg::S_RPAREN); tok(slr_pkg::S_LBRACE); gen_dcls();
    gen_stmts(0, $urandom_range(0, 3));
    tok(slr_pkg::S_RETURN); gen_expr(0); tok(slr_pkg::S_SEMI); tok(slr_pkg::S_RBRACE);
  endtask

  // ---- handshakes -------------------------------------------------------
  task automatic send_token(logic [5:0] k);
    int gap;
    if (tokens_sent % 32 == 0) in_burst = ($urandom_range(0, 3) == 0);
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_token_kind <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_token(k);
    tokens_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
  endtask

  // result checker, output stall pattern and idle watchdog
  always @(posedge clk) begin
    parse_word_t want;
    int hold;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL slr_shift_reduce_parser");
        $finish;
      end
      if (out_valid && !out_stall) begin
        words_seen++;
        if (events_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected word ev=%0d rule=%0d st=%0d depth=%0d last=%0b",
                   $time, out_event_res, out_rule_number, out_new_state,
                   out_stack_depth, out_last);
        end else begin
          want = events_due[0];
          events_due.delete(0);
          ev_count[want.ev]++;
          if (out_event_res !== want.ev || out_rule_number !== want.rule ||
              out_new_state !== want.st || out_stack_depth !== want.depth ||
              out_last !== want.last) begin
            fails++;
            $display("%0t: mismatch exp ev=%0d rule=%0d st=%0d depth=%0d last=%0b",
                     $time, want.ev, want.rule, want.st, want.depth, want.last);
            $display("%0t:          got ev=%0d rule=%0d st=%0d depth=%0d last=%0b",
                     $time, out_event_res, out_rule_number, out_new_state,
                     out_stack_depth, out_last);
          end
        end
        if (words_seen % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
        out_hold = out_burst ? 0 : $urandom_range(0, 14);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      hold = out_hold;
      out_stall <= (hold != 0);
    end
  end

  // ---- tests ------------------------------------------------------------
  // full program: procedures, then main with every statement kind and
  // every comparison, a deeply parenthesised return, then EOF and accept
  task automatic test_program();
    int deep;
    prog.delete();
    tok(slr_pkg::S_BOF);
    repeat (2) gen_proc();
    tok(slr_pkg::S_INT); tok(slr_pkg::S_WAIN); tok(slr_pkg::S_LPAREN); gen_dcl();
    tok(slr_pkg::S_COMMA); gen_dcl();
    tok(slr_pkg::S_RPAREN); tok(slr_pkg::S_LBRACE); gen_dcls();
    for (int k = 0; k < 5; k++) gen_stmt(k, 0);
    for (int op = 0; op < 6; op++) begin
      tok(slr_pkg::S_WHILE); tok(slr_pkg::S_LPAREN); gen_test(1, op);
      tok(slr_pkg::S_RPAREN); tok(slr_pkg::S_LBRACE); tok(slr_pkg::S_RBRACE);
    end
    while (prog.size() < 300) gen_stmt($urandom_range(0, 4), 0);
    // nesting depth pushes the stack past seventy entries
    deep = 60;
    tok(slr_pkg::S_RETURN);
    repeat (deep) tok(slr_pkg::S_LPAREN);
    tok(slr_pkg::S_ID);
    repeat (deep) tok(slr_pkg::S_RPAREN);
    tok(slr_pkg::S_SEMI); tok(slr_pkg::S_RBRACE); tok(slr_pkg::S_EOF);
    foreach (prog[i]) begin
      send_token(prog[i]);
      // one full pause mid-program until every word is out
      if (i == prog.size() / 2) drain();
    end
  endtask

  // after accept the stack top has no shifts; the error then sticks
  task automatic test_after_accept();
    logic [5:0] kinds[$];
    kinds = '{slr_pkg::S_BOF, slr_pkg::S_EOF, slr_pkg::S_INT, slr_pkg::S_NEW,
              6'd35, 6'd63, 6'd42, 6'd21};
    foreach (kinds[i]) send_token(kinds[i]);
  endtask

  task automatic test_noise();
    repeat (60) send_token(6'($urandom_range(0, 63)));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_token_kind = 6'd0;
    out_stall     = 1'b0;
    fails         = 0;
    tokens_sent   = 0;
    words_seen    = 0;
    idle_cycles   = 0;
    out_hold      = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    have_pend     = 1'b0;
    ev_count      = '{0, 0, 0, 0};
    build_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_program();
    test_after_accept();
    test_noise();

    drain();
    repeat (20) @(posedge clk);
    $display("Parsed %0d tokens into %0d words: %0d reduce, %0d shift, %0d accept, %0d error.",
             tokens_sent, words_seen, ev_count[0], ev_count[1], ev_count[3], ev_count[2]);
    if (fails == 0) begin
      $display("PASS slr_shift_reduce_parser");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAIL slr_shift_reduce_parser");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* slr_shift_reduce_parser.f */
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_act_rom.sv
rtl/slr_shift_reduce_parser.sv
tb/sv/slr_shift_reduce_parser_tb.sv
